FILE: hw/rtl/rvn_pkg.sv
// Shared types and constants for the RMS vector normaliser.
`default_nettype none
package rvn_pkg;

    localparam int VALUE_W  = 24;
    localparam int WEIGHT_W = 16;
    localparam int SUM_W    = 54;
    localparam int ROOT_W   = 32;
    localparam int EPS_W    = 32;
    localparam int RW_W     = 7;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 32;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_ROW_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_EPSILON    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_USE_WEIGHT = 2'd2;

    localparam logic [RW_W-1:0]         ROW_WIDTH_RST = 7'd64;
    localparam logic [EPS_W-1:0]        EPSILON_RST   = 32'd4295;
    localparam logic signed [WEIGHT_W-1:0] GAIN_ONE   = 16'sd4096;

    localparam logic [SUM_W-1:0] SAT_POS = 54'd8388607;
    localparam logic [SUM_W-1:0] SAT_NEG = 54'd8388608;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MEAN_GO,
        ST_MEAN,
        ST_SQRT,
        ST_READ,
        ST_FETCH,
        ST_DIV_GO,
        ST_DIV,
        ST_OUT
    } rvn_state_t;

    // Request to the shared divider
    typedef struct packed {
        logic             start;
        logic [SUM_W-1:0] dividend;
        logic [ROOT_W-1:0] divisor;
    } div_req_t;

    // Divider status
    typedef struct packed {
        logic             done;
        logic [SUM_W-1:0] quotient;
    } div_rsp_t;

endpackage
`default_nettype wire

FILE: hw/rtl/rvn_if.sv
// Stream and configuration channel interfaces for the RMS vector normaliser.
`default_nettype none
interface rvn_elem_if
    import rvn_pkg::*;
;
    logic                        valid;
    logic                        ready;
    logic signed [VALUE_W-1:0]   elem_value;
    logic signed [WEIGHT_W-1:0]  elem_weight;

    modport source (output valid, elem_value, elem_weight, input ready);
    modport sink   (input valid, elem_value, elem_weight, output ready);
endinterface

interface rvn_norm_if
    import rvn_pkg::*;
;
    logic                      valid;
    logic                      ready;
    logic signed [VALUE_W-1:0] norm_value;
    logic                      last_of_row;

    modport source (output valid, norm_value, last_of_row, input ready);
    modport sink   (input valid, norm_value, last_of_row, output ready);
endinterface

interface rvn_cfg_if
    import rvn_pkg::*;
;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DAT_W-1:0]  data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface
`default_nettype wire

FILE: hw/rtl/rms_vector_normalizer_unit.sv
// RMS vector normaliser top level: element store, sequencer, square root and output stage.
// Elements are taken one per cycle while the block is idle and stored in on-chip memory while
// the sum of squares accumulates. After the last element of a vector the block is busy: the mean
// square is formed by the shared restoring divider, the square root by a bit-pair iteration,
// and then each element is read back, multiplied by its gain and divided by the rms in the same
// divider before its output request; when the rms is zero the divider is skipped. The divider
// produces one quotient bit per cycle.
`default_nettype none
module rms_vector_normalizer_unit
    import rvn_pkg::*;
#(
    parameter int MAX_WIDTH = 64
)
(
    input wire          clk,
    input wire          rst_n,
    rvn_cfg_if.sink     cfg,
    rvn_elem_if.sink    elem_in,
    rvn_norm_if.source  norm_out
);

    localparam int IDX_W = $clog2(MAX_WIDTH);
    localparam int CNT_W = $clog2(MAX_WIDTH + 1);
    localparam logic [RW_W-1:0] MAX_W = RW_W'(MAX_WIDTH);

    // Configuration registers
    logic [RW_W-1:0]  row_width_reg;
    logic [EPS_W-1:0] epsilon_reg;
    logic             use_weight_reg;

    rvn_state_t state_reg, state_next;

    logic [CNT_W-1:0]  count_reg;
    logic [SUM_W-1:0]  sum_reg;
    logic [IDX_W-1:0]  k_reg;
    logic [ROOT_W-1:0] root_reg;
    logic [ROOT_W-1:0] sq_rem_reg;
    logic [63:0]       sq_x_reg;
    logic [4:0]        sq_cnt_reg;
    logic signed [VALUE_W+WEIGHT_W-1:0] prod_reg;
    logic signed [VALUE_W-1:0]  norm_reg;
    logic                       last_reg;

    logic signed [VALUE_W-1:0]  value_mem [MAX_WIDTH];
    logic signed [WEIGHT_W-1:0] weight_mem [MAX_WIDTH];
    logic signed [VALUE_W-1:0]  rd_value_reg;
    logic signed [WEIGHT_W-1:0] rd_weight_reg;

    logic [RW_W-1:0] width_eff;
    logic [RW_W-1:0] count_inc;
    logic            accept;
    logic            row_done;
    logic            out_take;
    logic            is_last;
    logic signed [2*VALUE_W-1:0] square;
    logic [SUM_W-1:0] sum_next;
    logic [SUM_W-1:0] ms;
    logic [ROOT_W+1:0] rem_sh;
    logic [ROOT_W+1:0] trial;
    logic              sq_fits;
    logic signed [WEIGHT_W-1:0] gain;
    logic [VALUE_W+WEIGHT_W-2:0] mag;
    logic [SUM_W-1:0]  num;
    logic [SUM_W-1:0]  quo;
    logic signed [VALUE_W-1:0] sat_val;
    div_req_t div_req;
    div_rsp_t div_rsp;

    rvn_divider u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    // Configuration writes
    assign cfg.ready = 1'b1;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_width_reg  <= ROW_WIDTH_RST;
            epsilon_reg    <= EPSILON_RST;
            use_weight_reg <= 1'b1;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                CFG_ROW_WIDTH:  row_width_reg  <= cfg.data[RW_W-1:0];
                CFG_EPSILON:    epsilon_reg    <= cfg.data[EPS_W-1:0];
                CFG_USE_WEIGHT: use_weight_reg <= cfg.data[0];
                default: ;
            endcase
        end
    end

    // Effective width and element intake
    always_comb
    begin
        if (row_width_reg == '0)
            width_eff = RW_W'(1);
        else if (row_width_reg > MAX_W)
            width_eff = MAX_W;
        else
            width_eff = row_width_reg;
        accept    = elem_in.valid && elem_in.ready;
        count_inc = RW_W'(count_reg) + RW_W'(1);
        row_done  = count_inc >= width_eff;
        square    = elem_in.elem_value * elem_in.elem_value;
        sum_next  = sum_reg + SUM_W'(unsigned'(square));
    end

    // Mean square plus epsilon, and square root step
    always_comb
    begin
        quo     = div_rsp.quotient;
        ms      = quo + SUM_W'(epsilon_reg);
        rem_sh  = {sq_rem_reg, sq_x_reg[63:62]};
        trial   = {root_reg, 2'b01};
        sq_fits = rem_sh >= trial;
    end

    // Scaled numerator with rounding term
    always_comb
    begin
        mag = prod_reg[VALUE_W+WEIGHT_W-1]
            ? (VALUE_W+WEIGHT_W-1)'(-prod_reg)
            : prod_reg[VALUE_W+WEIGHT_W-2:0];
        num = SUM_W'({mag, 12'b0}) + SUM_W'(root_reg >> 1);
        gain = use_weight_reg ? rd_weight_reg : GAIN_ONE;
    end

    // Saturate and restore sign
    always_comb
    begin
        if (prod_reg[VALUE_W+WEIGHT_W-1])
            sat_val = (quo > SAT_NEG) ? -VALUE_W'(SAT_NEG) : -VALUE_W'(quo);
        else
            sat_val = (quo > SAT_POS) ? VALUE_W'(SAT_POS) : VALUE_W'(quo);
    end

    assign is_last  = (CNT_W'(k_reg) + CNT_W'(1)) == count_reg;
    assign out_take = norm_out.valid && norm_out.ready;

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    // Next state and handshake outputs
    always_comb
    begin
        state_next       = state_reg;
        elem_in.ready    = 1'b0;
        norm_out.valid   = 1'b0;
        div_req.start    = 1'b0;
        div_req.dividend = sum_reg;
        div_req.divisor  = ROOT_W'(count_reg);
        unique case (state_reg)
            ST_IDLE:
            begin
                elem_in.ready = 1'b1;
                if (accept && row_done)
                    state_next = ST_MEAN_GO;
            end
            ST_MEAN_GO:
            begin
                div_req.start = 1'b1;
                state_next    = ST_MEAN;
            end
            ST_MEAN:
            begin
                if (div_rsp.done)
                    state_next = ST_SQRT;
            end
            ST_SQRT:
            begin
                if (sq_cnt_reg == '0)
                    state_next = ST_READ;
            end
            ST_READ:  state_next = ST_FETCH;
            ST_FETCH: state_next = ST_DIV_GO;
            ST_DIV_GO:
            begin
                if (root_reg == '0)
                    state_next = ST_OUT;
                else
                begin
                    div_req.start    = 1'b1;
                    div_req.dividend = num;
                    div_req.divisor  = root_reg;
                    state_next       = ST_DIV;
                end
            end
            ST_DIV:
            begin
                if (div_rsp.done)
                    state_next = ST_OUT;
            end
            ST_OUT:
            begin
                norm_out.valid = 1'b1;
                if (out_take)
                    state_next = is_last ? ST_IDLE : ST_READ;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Element memories, registered read
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            value_mem[count_reg[IDX_W-1:0]]  <= elem_in.elem_value;
            weight_mem[count_reg[IDX_W-1:0]] <= elem_in.elem_weight;
        end
        rd_value_reg  <= value_mem[k_reg];
        rd_weight_reg <= weight_mem[k_reg];
    end

    // Control counters and accumulator
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg  <= '0;
            sum_reg    <= '0;
            k_reg      <= '0;
            sq_cnt_reg <= '0;
        end
        else
        begin
            if (accept)
            begin
                count_reg <= count_reg + 1'b1;
                sum_reg   <= sum_next;
            end
            if (state_reg == ST_MEAN && div_rsp.done)
            begin
                sq_cnt_reg <= 5'd31;
                k_reg      <= '0;
            end
            else if (state_reg == ST_SQRT)
                sq_cnt_reg <= sq_cnt_reg - 1'b1;
            if (state_reg == ST_OUT && out_take)
            begin
                if (is_last)
                begin
                    count_reg <= '0;
                    sum_reg   <= '0;
                    k_reg     <= '0;
                end
                else
                    k_reg <= k_reg + 1'b1;
            end
        end
    end

    // Square root and per-element datapath
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_MEAN && div_rsp.done)
        begin
            sq_x_reg   <= {ms[47:0], 16'b0};
            sq_rem_reg <= '0;
            root_reg   <= '0;
        end
        else if (state_reg == ST_SQRT)
        begin
            sq_x_reg <= {sq_x_reg[61:0], 2'b00};
            if (sq_fits)
            begin
                sq_rem_reg <= ROOT_W'(rem_sh - trial);
                root_reg   <= {root_reg[ROOT_W-2:0], 1'b1};
            end
            else
            begin
                sq_rem_reg <= rem_sh[ROOT_W-1:0];
                root_reg   <= {root_reg[ROOT_W-2:0], 1'b0};
            end
        end
        if (state_reg == ST_FETCH)
            prod_reg <= rd_value_reg * gain;
        if (state_reg == ST_DIV_GO)
        begin
            norm_reg <= '0;
            last_reg <= is_last;
        end
        if (state_reg == ST_DIV && div_rsp.done)
            norm_reg <= sat_val;
    end

    assign norm_out.norm_value  = norm_reg;
    assign norm_out.last_of_row = last_reg;

`ifndef SYNTHESIS
    a_ready_no_out: assert property (@(posedge clk) disable iff (!rst_n)
        elem_in.ready |-> !norm_out.valid && count_reg < CNT_W'(MAX_WIDTH))
        else $error("intake open while results pending or store full");
    a_row_clears: assert property (@(posedge clk) disable iff (!rst_n)
        out_take && norm_out.last_of_row |=> count_reg == '0 && sum_reg == '0)
        else $error("vector state not cleared after last result");
    a_out_index: assert property (@(posedge clk) disable iff (!rst_n)
        norm_out.valid |-> CNT_W'(k_reg) < count_reg)
        else $error("result index beyond stored elements");
    a_sqrt_after_mean: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(state_reg == ST_SQRT) |-> $past(state_reg) == ST_MEAN)
        else $error("square root started without a mean");
`endif

endmodule
`default_nettype wire

FILE: hw/rtl/rvn_divider.sv
// Shared restoring divider, one quotient bit per cycle.
`default_nettype none
module rvn_divider
    import rvn_pkg::*;
(
    input  wire      clk,
    input  wire      rst_n,
    input  div_req_t req,
    output div_rsp_t rsp
);

    localparam int CNT_W = $clog2(SUM_W);

    logic              busy_reg;
    logic              done_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic [SUM_W-1:0]  dvd_reg;
    logic [SUM_W-1:0]  quo_reg;
    logic [ROOT_W-1:0] rem_reg;
    logic [ROOT_W-1:0] dsr_reg;

    logic [ROOT_W:0]   rem_sh;
    logic              fits;

    // One trial subtraction
    always_comb
    begin
        rem_sh = {rem_reg, dvd_reg[SUM_W-1]};
        fits   = rem_sh >= {1'b0, dsr_reg};
    end

    // Control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(SUM_W - 1);
            end
            else if (busy_reg)
            begin
                if (cnt_reg == '0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
                else
                begin
                    cnt_reg <= cnt_reg - 1'b1;
                end
            end
        end
    end

    // Datapath
    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            dvd_reg <= req.dividend;
            dsr_reg <= req.divisor;
            rem_reg <= '0;
            quo_reg <= '0;
        end
        else if (busy_reg)
        begin
            dvd_reg <= {dvd_reg[SUM_W-2:0], 1'b0};
            quo_reg <= {quo_reg[SUM_W-2:0], fits};
            rem_reg <= fits ? ROOT_W'(rem_sh - {1'b0, dsr_reg}) : rem_sh[ROOT_W-1:0];
        end
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg;

`ifndef SYNTHESIS
    a_no_restart: assert property (@(posedge clk) disable iff (!rst_n)
        req.start |-> !busy_reg)
        else $error("divider restarted while busy");
    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> $past(busy_reg))
        else $error("divider done without a run");
    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |=> !done_reg)
        else $error("divider done held");
`endif

endmodule
`default_nettype wire

FILE: bench/tb_rvn_checker.sv
// Scoreboard for the RMS vector normaliser: predicts normalised outputs and compares them.
`default_nettype none
module tb_rvn_checker
    import rvn_pkg::*;
(
    input wire         clk,
    input wire         rst_n,
    rvn_cfg_if.sink    cfg,
    rvn_elem_if.sink   elem_in,
    rvn_norm_if.sink   norm_out,
    output int         fail_count,
    output int         pending
);

    localparam int MAX_WIDTH_C = 64;

    typedef struct {
        logic signed [VALUE_W-1:0] norm_value;
        logic                      last_of_row;
    } norm_exp_t;

    norm_exp_t expected_norms[$];

    // Shadow of the block's registers and vector store
    logic [RW_W-1:0]  row_width_q;
    logic [EPS_W-1:0] epsilon_q;
    logic             use_weight_q;
    logic signed [VALUE_W-1:0]  vals[MAX_WIDTH_C];
    logic signed [WEIGHT_W-1:0] gains[MAX_WIDTH_C];
    logic [SUM_W-1:0] sq_sum;
    int               count;

    function automatic logic [63:0] int_sqrt(input logic [63:0] x);
        logic [63:0] res;
        logic [63:0] bitv;
        res  = 0;
        bitv = 64'd1 << 62;
        while (bitv > x)
            bitv = bitv >> 2;
        while (bitv != 0)
        begin
            if (x >= res + bitv)
            begin
                x   = x - (res + bitv);
                res = (res >> 1) + bitv;
            end
            else
                res = res >> 1;
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    function automatic logic signed [VALUE_W-1:0] scale_elem(
        input logic signed [VALUE_W-1:0] v,
        input logic signed [WEIGHT_W-1:0] g,
        input logic [63:0] root);
        longint      prod;
        logic [63:0] mag;
        logic [63:0] q;
        prod = longint'(v) * longint'(g);
        mag  = (prod < 0) ? 64'(-prod) : 64'(prod);
        if (root == 0)
            return '0;
        q = ((mag << 12) + (root >> 1)) / root;
        if (prod < 0)
        begin
            if (q > 64'd8388608)
                q = 64'd8388608;
            return VALUE_W'(-q);
        end
        if (q > 64'd8388607)
            q = 64'd8388607;
        return VALUE_W'(q);
    endfunction

    // Take one element; emit the whole vector when it completes
    task automatic absorb_elem(input logic signed [VALUE_W-1:0] v,
                               input logic signed [WEIGHT_W-1:0] g);
        int          w;
        logic [63:0] mean_sq;
        logic [63:0] root;
        norm_exp_t   e;
        w = row_width_q;
        if (w == 0)
            w = 1;
        if (w > MAX_WIDTH_C)
            w = MAX_WIDTH_C;
        if (count >= MAX_WIDTH_C)
            count = MAX_WIDTH_C - 1;
        vals[count]  = v;
        gains[count] = g;
        sq_sum = sq_sum + SUM_W'(longint'(v) * longint'(v));
        count++;
        if (count < w)
            return;
        mean_sq = 64'(sq_sum) / 64'(count) + 64'(epsilon_q);
        root    = int_sqrt(mean_sq << 16);
        for (int k = 0; k < count; k++)
        begin
            e.norm_value  = scale_elem(vals[k], use_weight_q ? gains[k] : GAIN_ONE, root);
            e.last_of_row = (k + 1 == count);
            expected_norms = {expected_norms, e};
        end
        sq_sum = '0;
        count  = 0;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        norm_exp_t e;
        if (!rst_n)
        begin
            row_width_q  = ROW_WIDTH_RST;
            epsilon_q    = EPSILON_RST;
            use_weight_q = 1'b1;
            sq_sum       = '0;
            count        = 0;
            fail_count   = 0;
            expected_norms.delete();
            pending      = 0;
        end
        else
        begin
            // register writes
            if (cfg.valid && cfg.ready)
            begin
                case (cfg.index)
                    CFG_ROW_WIDTH:  row_width_q  = cfg.data[RW_W-1:0];
                    CFG_EPSILON:    epsilon_q    = cfg.data;
                    CFG_USE_WEIGHT: use_weight_q = cfg.data[0];
                    default: ;
                endcase
            end
            // compare output before absorbing, results are never same-cycle
            if (norm_out.valid && norm_out.ready)
            begin
                if (expected_norms.size() == 0)
                begin
                    $error("unexpected result norm_value=%0d", norm_out.norm_value);
                    fail_count++;
                end
                else
                begin
                    e = expected_norms.pop_front();
                    if (norm_out.norm_value !== e.norm_value)
                    begin
                        $error("norm_value expected %0d actual %0d",
                               e.norm_value, norm_out.norm_value);
                        fail_count++;
                    end
                    if (norm_out.last_of_row !== e.last_of_row)
                    begin
                        $error("last_of_row expected %0b actual %0b",
                               e.last_of_row, norm_out.last_of_row);
                        fail_count++;
                    end
                end
            end
            if (elem_in.valid && elem_in.ready)
                absorb_elem(elem_in.elem_value, elem_in.elem_weight);
            pending = expected_norms.size();
        end
    end

endmodule
`default_nettype wire

FILE: bench/tb_rms_vector_normalizer_unit.sv
// Testbench top for the RMS vector normaliser: stimulus, back-pressure and verdict.
`default_nettype none
module tb_rms_vector_normalizer_unit
    import rvn_pkg::*;
;
    logic clk;
    logic rst_n;
    int   fail_count;
    int   pending;
    int   cycle_count;
    bit   quiet_tail;
    bit   hold_sink;
    int   elems_sent;

    localparam int CYCLE_LIMIT = 3000000;
    // Register index with no register behind it
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE = 2'd3;

    rvn_cfg_if  cfg();
    rvn_elem_if elem_in();
    rvn_norm_if norm_out();

    rms_vector_normalizer_unit dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg),
        .elem_in  (elem_in),
        .norm_out (norm_out)
    );

    tb_rvn_checker scoreboard (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .elem_in    (elem_in),
        .norm_out   (norm_out),
        .fail_count (fail_count),
        .pending    (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever
            #5 clk = ~clk;
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // Result side: random stalls in bursts, long hold on request
    initial
    begin
        int gap;
        norm_out.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_sink)
            begin
                norm_out.ready <= 1'b0;
                repeat (400) @(negedge clk);
                hold_sink = 1'b0;
            end
            if (!quiet_tail && $urandom_range(0, 5) == 0)
            begin
                gap = $urandom_range(1, 9);
                norm_out.ready <= 1'b0;
                repeat (gap - 1) @(negedge clk);
            end
            else
                norm_out.ready <= 1'b1;
        end
    end

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] d);
        cfg.valid <= 1'b1;
        cfg.index <= idx;
        cfg.data  <= d;
        @(posedge clk);
        while (!cfg.ready)
            @(posedge clk);
        @(negedge clk);
        cfg.valid <= 1'b0;
        @(negedge clk);
    endtask

    // Offer one element, with an optional idle burst first; valid stays up afterwards
    task automatic send_elem(input logic signed [VALUE_W-1:0] v,
                             input logic signed [WEIGHT_W-1:0] g);
        if (!quiet_tail && $urandom_range(0, 4) == 0)
        begin
            elem_in.valid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(negedge clk);
        end
        elem_in.valid       <= 1'b1;
        elem_in.elem_value  <= v;
        elem_in.elem_weight <= g;
        @(posedge clk);
        while (!elem_in.ready)
            @(posedge clk);
        @(negedge clk);
        elems_sent++;
    endtask

    // Wait until all results are in, then let the block settle
    task automatic drain();
        elem_in.valid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (200) @(negedge clk);
    endtask

    function automatic logic signed [VALUE_W-1:0] rand_value();
        case ($urandom_range(0, 5))
            0: return 24'sh7FFFFF;
            1: return 24'sh800000;
            2: return VALUE_W'($urandom_range(0, 255)) - 24'sd128;
            default: return VALUE_W'($urandom);
        endcase
    endfunction

    function automatic logic signed [WEIGHT_W-1:0] rand_weight();
        case ($urandom_range(0, 4))
            0: return 16'sh7FFF;
            1: return 16'sh8000;
            2: return GAIN_ONE;
            default: return WEIGHT_W'($urandom);
        endcase
    endfunction

    task automatic send_row(input int n);
        for (int i = 0; i < n; i++)
            send_elem(rand_value(), rand_weight());
    endtask

    initial
    begin
        int w;
        cycle_count = 0;
        quiet_tail  = 1'b0;
        hold_sink   = 1'b0;
        elems_sent  = 0;
        cfg.valid = 1'b0;
        cfg.index = CFG_ROW_WIDTH;
        cfg.data  = '0;
        elem_in.valid       = 1'b0;
        elem_in.elem_value  = '0;
        elem_in.elem_weight = '0;
        rst_n = 1'b0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed: width one, field extremes, zero rms
        write_reg(CFG_ROW_WIDTH, 32'd1);
        write_reg(CFG_EPSILON, 32'd0);
        send_elem(24'sh000000, 16'sh7FFF);
        send_elem(24'sh7FFFFF, 16'sh7FFF);
        send_elem(24'sh800000, 16'sh8000);
        send_elem(24'sh000001, 16'shFFFF);
        drain();
        // Width zero acts as one; large epsilon; unit gain
        write_reg(CFG_ROW_WIDTH, 32'd0);
        write_reg(CFG_EPSILON, 32'hFFFFFFFF);
        write_reg(CFG_USE_WEIGHT, 32'd0);
        send_elem(24'sh123456, 16'sh1234);
        send_elem(24'shFEDCBA, 16'sh8000);
        drain();
        // Out-of-range index is ignored
        write_reg(CFG_IDX_SPARE, 32'd5);
        // Width two with all zeros and zero epsilon
        write_reg(CFG_ROW_WIDTH, 32'd2);
        write_reg(CFG_EPSILON, 32'd0);
        write_reg(CFG_USE_WEIGHT, 32'd1);
        send_elem(24'sh000000, 16'sh1000);
        send_elem(24'sh000000, 16'sh1000);
        // Near-outlier: small and large mixed, with extreme weights
        send_elem(24'sh000010, 16'sh7FFF);
        send_elem(24'sh000001, 16'sh8000);
        drain();
        // Width above maximum acts as maximum
        write_reg(CFG_ROW_WIDTH, 32'd127);
        write_reg(CFG_EPSILON, 32'd4295);
        send_row(64);
        drain();
        // Width lowered mid-vector
        write_reg(CFG_ROW_WIDTH, 32'd6);
        send_row(4);
        drain();
        write_reg(CFG_ROW_WIDTH, 32'd2);
        send_row(1);
        drain();

        // Random phases, mostly short rows
        for (int ph = 0; ph < 8; ph++)
        begin
            w = ($urandom_range(0, 3) == 0) ? int'($urandom_range(9, 16))
                                            : int'($urandom_range(1, 5));
            write_reg(CFG_ROW_WIDTH, CFG_DAT_W'(w));
            write_reg(CFG_EPSILON, ($urandom_range(0, 3) == 0) ? $urandom
                                                              : $urandom_range(0, 9000));
            write_reg(CFG_USE_WEIGHT, $urandom_range(0, 1));
            if (ph == 2)
                hold_sink = 1'b1;
            if (ph == 7)
                quiet_tail = 1'b1;
            send_row(w * (8 / w + 1));
            drain();
        end

        if (fail_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
`default_nettype wire
